// ===== src/letter_multiset_subword_check_assert.svh =====
// Assertion macros for the checker file of the letter multiset check
`ifndef LETTER_MULTISET_SUBWORD_CHECK_ASSERT_SVH
`define LETTER_MULTISET_SUBWORD_CHECK_ASSERT_SVH

// Clocked assertion, switched off while reset is high
`define LMSC_ASSERT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);

// Clocked assertion that also holds through reset
`define LMSC_ASSERT_ALWAYS(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);

`endif

// ===== src/lmsc_pkg.sv =====
// Types, constants and helpers for the letter multiset subword check
package lmsc_pkg;

  // Default longest word kept as base
  localparam int MAX_WORD_LEN_DEF = 32;

  // Letter alphabet is the full byte range; counts saturate at 63
  localparam int ALPHA_N = 256;
  localparam int ALPHA_W = 8;
  localparam int CNT_W   = 6;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Result field width and depth of the result queue
  localparam int LEN_OUT_W = 6;
  localparam int RES_DEPTH = 3;

  // Word kinds on the func field
  localparam logic FUNC_BASE = 1'b0;
  localparam logic FUNC_CAND = 1'b1;

  typedef enum logic [1:0] {
    VERDICT_ACCEPT = 2'd0,
    VERDICT_LONGER = 2'd1,
    VERDICT_SAME   = 2'd2,
    VERDICT_SHORT  = 2'd3
  } verdict_t;

  typedef struct packed {
    logic               func;
    logic [ALPHA_W-1:0] letter;
    logic               first;
    logic               last;
  } item_t;

  typedef struct packed {
    verdict_t             verdict;
    logic [LEN_OUT_W-1:0] candidate_length;
  } result_t;

  // Per-letter control from the update stage to one count table
  typedef struct packed {
    logic clear;
    logic write;
  } tally_ctl_t;

  // A-Z map to a-z, every other byte is kept
  function automatic logic [ALPHA_W-1:0] fold_case(input logic [ALPHA_W-1:0] c);
    logic [ALPHA_W-1:0] r;
    r = c;
    if (c inside {[8'd65:8'd90]}) begin
      r = c + 8'd32;
    end
    return r;
  endfunction

  // Count increment that sticks at the top
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] x);
    logic [CNT_W-1:0] r;
    r = (x == CNT_MAX) ? x : x + 1'b1;
    return r;
  endfunction

endpackage

// ===== src/lmsc_ram.sv =====
// Generic single-write, single-read RAM with registered read data
module lmsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old contents when both ports hit one entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/lmsc_tally.sv =====
// One letter count table: RAM, presence bits for word clears, write forwarding
module lmsc_tally
  import lmsc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               rd_en,
  input  logic [ALPHA_W-1:0] rd_addr,
  input  logic [ALPHA_W-1:0] addr,
  input  tally_ctl_t         ctl,
  input  logic [CNT_W-1:0]   wr_data,
  output logic [CNT_W-1:0]   count
);

  logic [CNT_W-1:0]   ram_q;
  logic [ALPHA_N-1:0] present;
  logic [ALPHA_N-1:0] present_next;
  logic               fwd_valid;
  logic [ALPHA_W-1:0] fwd_addr;
  logic [CNT_W-1:0]   fwd_data;
  logic               fwd_hit;

  lmsc_ram #(
    .WIDTH (CNT_W),
    .DEPTH (ALPHA_N)
  ) u_ram (
    .clk   (clk),
    .we    (ctl.write),
    .waddr (addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  // Count seen by the word now in the update stage
  assign fwd_hit = fwd_valid && (fwd_addr == addr);

  always_comb begin
    if (ctl.clear || !present[addr]) begin
      count = '0;
    end else if (fwd_hit) begin
      count = fwd_data;
    end else begin
      count = ram_q;
    end
  end

  // Presence bits: a new word wipes them all at once
  always_comb begin
    present_next = ctl.clear ? '0 : present;
    if (ctl.write) begin
      present_next[addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      present   <= '0;
      fwd_valid <= 1'b0;
    end else begin
      present <= present_next;
      if (ctl.write) begin
        fwd_valid <= 1'b1;
      end
    end
  end

  // Last write, covers a read that met the write at the same edge
  always_ff @(posedge clk) begin
    if (ctl.write) begin
      fwd_addr <= addr;
      fwd_data <= wr_data;
    end
  end

endmodule

// ===== src/lmsc_result_fifo.sv =====
// Small result queue between the update stage and the result port
module lmsc_result_fifo
  import lmsc_pkg::*;
(
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  input  result_t                        push_data,
  input  logic                           pop_ready,
  output logic                           valid,
  output result_t                        data,
  output logic [$clog2(RES_DEPTH+1)-1:0] count
);

  localparam int PTR_W = $clog2(RES_DEPTH);
  localparam int CNT_BITS = $clog2(RES_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RES_DEPTH - 1);

  result_t              slot [RES_DEPTH];
  logic [PTR_W-1:0]     wptr;
  logic [PTR_W-1:0]     rptr;
  logic                 pop;

  assign valid = (count != '0);
  assign data  = slot[rptr];
  assign pop   = valid && pop_ready;

  // Pointers wrap at the queue depth
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PTR_LAST) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PTR_LAST) ? '0 : rptr + 1'b1;
      end
      count <= count + CNT_BITS'(push) - CNT_BITS'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wptr] <= push_data;
    end
  end

endmodule

// ===== src/letter_multiset_subword_check.sv =====
// Top level: letter multiset containment check against a stored base word
//
//  port group   dir  handshake                  carries
//  item         in   item_valid / item_ready      item_t: func, letter, first, last
//  result       out  result_valid / result_ready  result_t: verdict, candidate_length
//
// A new letter can be taken while the one before it is still in the update stage.
// The accept edge launches the count RAM and base text reads; the following cycle
// does the read-modify-write and pushes the verdict into the result queue.
// Reset clears the presence bits of both count tables at once: no clearing pass.
// item_ready falls only when the three-entry result queue plus a verdict in flight
// would leave no room for another verdict.
module letter_multiset_subword_check
  import lmsc_pkg::*;
#(
  parameter int MAX_WORD_LEN = MAX_WORD_LEN_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  localparam int LEN_W  = $clog2(MAX_WORD_LEN + 2);
  localparam int TXT_AW = $clog2(MAX_WORD_LEN);
  localparam int QCNT_W = $clog2(RES_DEPTH + 1);
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_WORD_LEN);

  logic              accept;
  item_t             item_fold;
  logic              s1_valid;
  item_t             s1_item;

  logic [LEN_W-1:0]  base_len;
  logic [LEN_W-1:0]  base_len_next;
  logic [LEN_W-1:0]  word_len;
  logic [LEN_W-1:0]  word_len_next;
  logic              shortage;
  logic              shortage_next;
  logic              same;
  logic              same_next;

  logic              is_base;
  logic              is_cand;
  logic [LEN_W-1:0]  base_len_eff;
  logic [LEN_W-1:0]  word_len_eff;
  logic              base_take;
  tally_ctl_t        base_ctl;
  tally_ctl_t        word_ctl;
  logic [CNT_W-1:0]  base_cnt;
  logic [CNT_W-1:0]  word_cnt;
  logic [CNT_W-1:0]  base_cnt_new;
  logic [CNT_W-1:0]  word_cnt_new;

  logic [TXT_AW-1:0] txt_raddr;
  logic [TXT_AW-1:0] txt_waddr;
  logic [TXT_AW-1:0] txt_s1_addr;
  logic [ALPHA_W-1:0] txt_q;
  logic [ALPHA_W-1:0] txt_char;
  logic              txt_fwd_valid;
  logic [TXT_AW-1:0] txt_fwd_addr;
  logic [ALPHA_W-1:0] txt_fwd_data;

  logic              res_push;
  result_t           res_data;
  logic [QCNT_W-1:0] res_count;

  // Input side
  assign accept = item_valid && item_ready;

  always_comb begin
    item_fold        = item;
    item_fold.letter = fold_case(item.letter);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= item_fold;
    end
  end

  // Update stage decode
  assign is_base      = s1_valid && (s1_item.func == FUNC_BASE);
  assign is_cand      = s1_valid && (s1_item.func == FUNC_CAND);
  assign base_len_eff = (is_base && s1_item.first) ? '0 : base_len;
  assign word_len_eff = (is_cand && s1_item.first) ? '0 : word_len;
  assign base_take    = is_base && (base_len_eff < MAX_LEN);

  assign base_ctl.clear = is_base && s1_item.first;
  assign base_ctl.write = base_take;
  assign word_ctl.clear = is_cand && s1_item.first;
  assign word_ctl.write = is_cand;

  assign base_cnt_new = sat_inc(base_cnt);
  assign word_cnt_new = sat_inc(word_cnt);

  lmsc_tally u_base_tally (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (item_fold.letter),
    .addr    (s1_item.letter),
    .ctl     (base_ctl),
    .wr_data (base_cnt_new),
    .count   (base_cnt)
  );

  lmsc_tally u_word_tally (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (item_fold.letter),
    .addr    (s1_item.letter),
    .ctl     (word_ctl),
    .wr_data (word_cnt_new),
    .count   (word_cnt)
  );

  // Base text: written by base letters, read at the candidate's position
  assign txt_waddr   = TXT_AW'(base_len_eff);
  assign txt_s1_addr = TXT_AW'(word_len_eff);

  always_comb begin
    if (item.first || (word_len_next >= MAX_LEN)) begin
      txt_raddr = '0;
    end else begin
      txt_raddr = TXT_AW'(word_len_next);
    end
  end

  lmsc_ram #(
    .WIDTH (ALPHA_W),
    .DEPTH (MAX_WORD_LEN)
  ) u_text_ram (
    .clk   (clk),
    .we    (base_take),
    .waddr (txt_waddr),
    .wdata (s1_item.letter),
    .re    (accept),
    .raddr (txt_raddr),
    .rdata (txt_q)
  );

  assign txt_char = (txt_fwd_valid && (txt_fwd_addr == txt_s1_addr)) ? txt_fwd_data : txt_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      txt_fwd_valid <= 1'b0;
    end else if (base_take) begin
      txt_fwd_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (base_take) begin
      txt_fwd_addr <= txt_waddr;
      txt_fwd_data <= s1_item.letter;
    end
  end

  // Word state next values
  always_comb begin
    base_len_next = base_len;
    word_len_next = word_len;
    shortage_next = shortage;
    same_next     = same;
    if (is_base) begin
      base_len_next = base_take ? base_len_eff + 1'b1 : base_len_eff;
    end
    if (is_cand) begin
      shortage_next = (!s1_item.first && shortage) || (word_cnt_new > base_cnt);
      same_next     = (s1_item.first || same) && (word_len_eff < base_len)
                      && (txt_char == s1_item.letter);
      word_len_next = (word_len_eff <= MAX_LEN) ? word_len_eff + 1'b1 : word_len_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_len <= '0;
      word_len <= '0;
      shortage <= 1'b0;
      same     <= 1'b0;
    end else begin
      base_len <= base_len_next;
      word_len <= word_len_next;
      shortage <= shortage_next;
      same     <= same_next;
    end
  end

  // Verdict on a candidate's last letter
  assign res_push = is_cand && s1_item.last;

  always_comb begin
    res_data.candidate_length = LEN_OUT_W'(word_len_next);
    if (word_len_next > base_len) begin
      res_data.verdict = VERDICT_LONGER;
    end else if (same_next && (word_len_next == base_len)) begin
      res_data.verdict = VERDICT_SAME;
    end else if (shortage_next) begin
      res_data.verdict = VERDICT_SHORT;
    end else begin
      res_data.verdict = VERDICT_ACCEPT;
    end
  end

  lmsc_result_fifo u_result_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .push_data (res_data),
    .pop_ready (result_ready),
    .valid     (result_valid),
    .data      (result),
    .count     (res_count)
  );

  // Room for this word's verdict after one still in flight
  assign item_ready = ({1'b0, res_count} + (QCNT_W + 1)'(res_push))
                      < (QCNT_W + 1)'(RES_DEPTH);

endmodule

// ===== src/lmsc_check.sv =====
// Port-level checker for the letter multiset check, with its bind
`include "letter_multiset_subword_check_assert.svh"

module lmsc_check
  import lmsc_pkg::*;
#(
  parameter int MAX_WORD_LEN = MAX_WORD_LEN_DEF
) (
  input logic    clk,
  input logic    rst,
  input logic    item_valid,
  input logic    item_ready,
  input item_t   item,
  input logic    result_valid,
  input logic    result_ready,
  input result_t result
);

  localparam logic [LEN_OUT_W-1:0] MAX_LEN = LEN_OUT_W'(MAX_WORD_LEN);

  // A stalled verdict word holds
  `LMSC_ASSERT(a_result_hold, clk, rst, result_valid && !result_ready |=> result_valid && $stable(result), "result word changed while stalled")

  // Every verdict covers at least one letter
  `LMSC_ASSERT(a_len_nonzero, clk, rst, result_valid |-> result.candidate_length != '0, "verdict with zero length")

  // Not longer than the base means within the base limit
  `LMSC_ASSERT(a_accept_len, clk, rst, result_valid && result.verdict == VERDICT_ACCEPT |-> result.candidate_length <= MAX_LEN, "accepted word too long")

  `LMSC_ASSERT(a_same_len, clk, rst, result_valid && result.verdict == VERDICT_SAME |-> result.candidate_length <= MAX_LEN, "same-as-base word too long")

  // Reset empties the result queue
  `LMSC_ASSERT_ALWAYS(a_reset_empty, clk, $past(rst) |-> !result_valid, "result valid after reset")

endmodule

bind letter_multiset_subword_check lmsc_check #(.MAX_WORD_LEN(MAX_WORD_LEN)) u_lmsc_check (.*);
